[design/snbu_pkg.sv]
package snbu_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = 12;
    localparam int ACC_WIDTH   = 40;
    localparam int SIG_POINTS  = 257;
    localparam int SEG_W       = 9;
    localparam int RATE_WIDTH  = 13;
    localparam int RATE_FRAC   = 12;
    localparam int RATE_RESET  = 819;
    localparam int TAB_W       = 13;
    localparam int MUL_A_W     = 28;
    localparam int MUL_B_W     = 21;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int SAT_IN_W    = 40;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TUSER_W = 3;

    typedef enum logic [1:0] {
        FN_FORWARD  = 2'd0,
        FN_OUT_GRAD = 2'd1,
        FN_HID_GRAD = 2'd2,
        FN_UPDATE   = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERM,
        ST_ACC,
        ST_SIG,
        ST_DERIV,
        ST_GRAD,
        ST_RATE,
        ST_STEP,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         flag;
    } sat_t;

    typedef logic [TAB_W-1:0] sig_entry_t;
    typedef sig_entry_t sig_tab_t [SIG_POINTS];

    function automatic sat_t sat_data(input logic signed [SAT_IN_W-1:0] v);
        sat_t res;
        res.flag  = 1'b0;
        res.value = DATA_WIDTH'(v);
        if (v > SAT_IN_W'(signed'({1'b0, {(DATA_WIDTH-1){1'b1}}}))) begin
            res.flag  = 1'b1;
            res.value = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end else if (v < -SAT_IN_W'(signed'({1'b0, 1'b1, {(DATA_WIDTH-1){1'b0}}}))) begin
            res.flag  = 1'b1;
            res.value = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end
        return res;
    endfunction

    // restoring long division, used only while building the table
    function automatic longint unsigned long_div(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sigmoid points over [-8,8]: Taylor series of exp(-|x|/16), four squarings
    function automatic sig_tab_t build_sig_tab();
        sig_tab_t          tab;
        longint            sx;
        longint unsigned   num;
        longint unsigned   term;
        longint unsigned   acc;
        longint unsigned   e;
        longint unsigned   d2;
        longint unsigned   den;
        longint unsigned   q30;
        longint unsigned   dv;
        den = longint'(SIG_POINTS - 1);
        q30 = 64'd1 << 30;
        for (int k = 0; k < SIG_POINTS; k++) begin
            sx   = 16 * longint'(k) - 8 * longint'(den);
            num  = (sx < 0) ? longint'(-sx) : longint'(sx);
            term = q30;
            acc  = q30;
            for (int n = 1; n <= 24; n++) begin
                dv   = 64'd16 * den * longint'(n);
                term = long_div(term * num, dv);
                if (n[0]) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            e = acc;
            for (int n = 0; n < 4; n++) begin
                e = (e * e + (q30 >> 1)) >> 30;
            end
            d2 = q30 + e;
            if (sx >= 0) begin
                tab[k] = TAB_W'(long_div(((64'd1 << FRAC_BITS) << 30) + (d2 >> 1), d2));
            end else begin
                tab[k] = TAB_W'(long_div((e << FRAC_BITS) + (d2 >> 1), d2));
            end
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

[design/sigmoid_neuron_backprop_unit_core.sv]
// Sigmoid backpropagation neuron in signed Q3.12. An item is taken when the
// unit is idle and is worked through a small sequencer around one shared
// 28x21 signed multiplier, one product per cycle. States per item: TERM, ACC
// for a non-last forward or hidden term; TERM, ACC, SIG, FIN for a last
// forward term; TERM, ACC, DERIV, GRAD, FIN for a last hidden term; DERIV,
// GRAD, FIN for an output gradient; RATE, STEP, FIN for a weight update.
// FIN waits while an earlier result is still held in the output register
// for m_tready. The sigmoid is a 257-point constant
// table with linear interpolation; learning_rate is written through cfg_we.
module sigmoid_neuron_backprop_unit_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [snbu_pkg::IN_TDATA_W-1:0]       s_tdata,   // value[15:0], weight[31:16]
    input  logic                                  s_tlast,
    input  logic [snbu_pkg::IN_TUSER_W-1:0]       s_tuser,   // func[1:0]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [snbu_pkg::DATA_WIDTH-1:0]       m_tdata,   // result_value[15:0]
    output logic [snbu_pkg::OUT_TUSER_W-1:0]      m_tuser,   // result_kind[1:0], saturated[2]
    input  logic                                  cfg_we,
    input  logic [snbu_pkg::RATE_WIDTH-1:0]       cfg_wdata
);
    import snbu_pkg::*;

    state_t                         state_reg, state_next;
    logic [RATE_WIDTH-1:0]          rate_reg;
    logic signed [ACC_WIDTH-1:0]    acc_reg, acc_next;
    logic                           ovf_reg, ovf_next;
    logic signed [DATA_WIDTH-1:0]   out_reg, out_next;
    logic signed [DATA_WIDTH-1:0]   grad_reg, grad_next;
    func_t                          func_reg;
    logic signed [DATA_WIDTH-1:0]   value_reg, weight_reg;
    logic                           last_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic                           prod_en;
    logic                           mflag_reg, mflag_next;
    logic                           mv_reg, mv_next;
    logic signed [DATA_WIDTH-1:0]   md_reg, md_next;
    func_t                          mk_reg, mk_next;
    logic                           ms_reg, ms_next;
    logic                           take;

    logic signed [MUL_A_W-1:0]      mul_a;
    logic signed [MUL_B_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]       mul_p;

    logic signed [ACC_WIDTH:0]      acc_sum;
    logic signed [ACC_WIDTH-1:0]    acc_add;
    logic                           acc_ovf;

    logic signed [MUL_A_W-1:0]      net, net_c, u_wide;
    logic [16:0]                    u;
    logic [SEG_W-1:0]               seg, idx_b;
    logic [15:0]                    frac;
    logic [TAB_W-1:0]               tab_a, tab_b;
    logic signed [TAB_W:0]          diff;
    logic signed [PROD_W-1:0]       rnd;
    logic [TAB_W:0]                 sig_y;

    logic signed [MUL_B_W-1:0]      deriv;
    logic signed [16:0]             one_minus_o;
    logic signed [16:0]             err;
    sat_t                           m_sat, g_sat, w_sat;

    assign s_tready = (state_reg == ST_IDLE);
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = {ms_reg, mk_reg};

    assign mul_p = mul_a * mul_b;

    // accumulator with saturation
    assign acc_sum = (ACC_WIDTH + 1)'(acc_reg) + (ACC_WIDTH + 1)'($signed(prod_reg[31:0]));
    assign acc_ovf = acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1];
    assign acc_add = acc_ovf ? (acc_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                                   : {1'b0, {(ACC_WIDTH-1){1'b1}}})
                             : acc_sum[ACC_WIDTH-1:0];

    // sigmoid segment lookup
    assign net = $signed(acc_reg[ACC_WIDTH-1:FRAC_BITS]);
    always_comb begin
        if (net > 28'sd32768) begin
            net_c = 28'sd32768;
        end else if (net < -28'sd32768) begin
            net_c = -28'sd32768;
        end else begin
            net_c = net;
        end
    end
    assign u_wide = net_c + 28'sd32768;
    assign u      = u_wide[16:0];
    assign seg    = u[16:8];
    assign frac   = {u[7:0], 8'h00};
    assign idx_b  = u[16] ? seg : seg + SEG_W'(1);
    assign tab_a  = SIG_TAB[seg];
    assign tab_b  = SIG_TAB[idx_b];
    assign diff   = $signed({1'b0, tab_b}) - $signed({1'b0, tab_a});
    assign rnd    = prod_reg + PROD_W'(32768);
    assign sig_y  = {1'b0, tab_a} + rnd[29:16];

    assign deriv       = $signed(prod_reg[32:12]);
    assign one_minus_o = 17'sd4096 - 17'(out_reg);
    assign err         = 17'(value_reg) - 17'(out_reg);

    assign m_sat = sat_data(SAT_IN_W'($signed(prod_reg[PROD_W-1:FRAC_BITS])));
    assign g_sat = sat_data(SAT_IN_W'($signed(prod_reg[PROD_W-1:FRAC_BITS])));
    assign w_sat = sat_data(SAT_IN_W'(weight_reg) +
                            SAT_IN_W'($signed(prod_reg[PROD_W-1:FRAC_BITS])));

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        out_next   = out_reg;
        grad_next  = grad_reg;
        mflag_next = mflag_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        mk_next    = mk_reg;
        ms_next    = ms_reg;
        prod_en    = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    mflag_next = 1'b0;
                    unique case (func_t'(s_tuser))
                        FN_FORWARD, FN_HID_GRAD: state_next = ST_TERM;
                        FN_OUT_GRAD:             state_next = ST_DERIV;
                        FN_UPDATE:               state_next = ST_RATE;
                        default:                 state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TERM: begin
                mul_a      = MUL_A_W'(value_reg);
                mul_b      = MUL_B_W'(weight_reg);
                prod_en    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_next = acc_add;
                ovf_next = ovf_reg | acc_ovf;
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (func_reg == FN_FORWARD) begin
                    state_next = ST_SIG;
                end else begin
                    state_next = ST_DERIV;
                end
            end
            ST_SIG: begin
                mul_a      = MUL_A_W'(diff);
                mul_b      = MUL_B_W'({1'b0, frac});
                prod_en    = 1'b1;
                state_next = ST_FIN;
            end
            ST_DERIV: begin
                mul_a      = MUL_A_W'(out_reg);
                mul_b      = MUL_B_W'(one_minus_o);
                prod_en    = 1'b1;
                state_next = ST_GRAD;
            end
            ST_GRAD: begin
                mul_a      = (func_reg == FN_OUT_GRAD) ? MUL_A_W'(err) : net;
                mul_b      = deriv;
                prod_en    = 1'b1;
                state_next = ST_FIN;
            end
            ST_RATE: begin
                mul_a      = MUL_A_W'({1'b0, rate_reg});
                mul_b      = MUL_B_W'(grad_reg);
                prod_en    = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                mflag_next = m_sat.flag;
                mul_a      = MUL_A_W'(m_sat.value);
                mul_b      = MUL_B_W'(value_reg);
                prod_en    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mk_next    = func_reg;
                    state_next = ST_IDLE;
                    unique case (func_reg)
                        FN_FORWARD: begin
                            md_next  = DATA_WIDTH'(sig_y);
                            ms_next  = ovf_reg;
                            out_next = DATA_WIDTH'(sig_y);
                            acc_next = '0;
                            ovf_next = 1'b0;
                        end
                        FN_OUT_GRAD: begin
                            md_next   = g_sat.value;
                            ms_next   = g_sat.flag;
                            grad_next = g_sat.value;
                        end
                        FN_HID_GRAD: begin
                            md_next   = g_sat.value;
                            ms_next   = g_sat.flag | ovf_reg;
                            grad_next = g_sat.value;
                            acc_next  = '0;
                            ovf_next  = 1'b0;
                        end
                        FN_UPDATE: begin
                            md_next = w_sat.value;
                            ms_next = w_sat.flag | mflag_reg;
                        end
                        default: begin
                            md_next = md_reg;
                        end
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rate_reg  <= RATE_WIDTH'(RATE_RESET);
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            out_reg   <= '0;
            grad_reg  <= '0;
            mv_reg    <= 1'b0;
            mflag_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            out_reg   <= out_next;
            grad_reg  <= grad_next;
            mv_reg    <= mv_next;
            mflag_reg <= mflag_next;
            if (cfg_we) begin
                rate_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            func_reg   <= func_t'(s_tuser);
            value_reg  <= $signed(s_tdata[DATA_WIDTH-1:0]);
            weight_reg <= $signed(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
            last_reg   <= s_tlast;
        end
        if (prod_en) begin
            prod_reg <= mul_p;
        end
        md_reg <= md_next;
        mk_reg <= mk_next;
        ms_reg <= ms_next;
    end

endmodule

[design/snbu_checker.sv]
module snbu_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [snbu_pkg::DATA_WIDTH-1:0]       m_tdata,
    input logic [snbu_pkg::OUT_TUSER_W-1:0]      m_tuser
);
    import snbu_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    a_new_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without work in progress");

    a_sig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == FN_FORWARD) |-> !m_tdata[DATA_WIDTH-1] &&
        (m_tdata <= DATA_WIDTH'(1 << FRAC_BITS)))
        else $error("neuron output outside [0,1]");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sigmoid_neuron_backprop_unit_core snbu_checker u_snbu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/sv/neuron_checker.sv]
module neuron_checker
    import snbu_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // value[15:0], weight[31:16]
    input  logic                   s_tlast,
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // func[1:0]
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [DATA_WIDTH-1:0]  m_tdata,   // result_value[15:0]
    input  logic [OUT_TUSER_W-1:0] m_tuser,   // result_kind[1:0], saturated[2]
    input  logic                   cfg_we,
    input  logic [RATE_WIDTH-1:0]  cfg_wdata,
    output int                     mismatches,
    output int                     outstanding,
    output int                     delivered,
    output int                     clamped
);

    localparam longint ACC_HI  = (longint'(1) << (ACC_WIDTH - 1)) - 1;
    localparam longint ACC_LO  = -ACC_HI - 1;
    localparam longint DATA_HI = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    localparam longint DATA_LO = -DATA_HI - 1;
    localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
    localparam longint unsigned Q30 = 64'd1 << 30;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic [1:0]            kind;
        logic                  sat;
    } neuron_result_t;

    neuron_result_t due_results[$];
    longint         curve [SIG_POINTS];
    longint         acc_sum;
    longint         out_q;
    longint         grad_q;
    bit             acc_ovf;
    longint         rate;
    int             miss_n;
    int             seen_n;
    int             sat_n;

    // exp(-|x|) by a Q30 series on |x|/16, squared four times
    function automatic void fill_curve();
        longint unsigned mag;
        longint unsigned term;
        longint unsigned series;
        longint unsigned e;
        longint unsigned denom;
        longint unsigned span;
        longint          x;
        span = SIG_POINTS - 1;
        for (int k = 0; k < SIG_POINTS; k++) begin
            x      = 16 * longint'(k) - 8 * longint'(span);
            mag    = (x < 0) ? -x : x;
            term   = Q30;
            series = Q30;
            for (int n = 1; n <= 24; n++) begin
                term   = term * mag / (64'd16 * span * n);
                series = n[0] ? series - term : series + term;
            end
            e = series;
            repeat (4) e = (e * e + (Q30 >> 1)) >> 30;
            denom = Q30 + e;
            if (x >= 0) begin
                curve[k] = longint'(((Q30 << FRAC_BITS) + denom / 2) / denom);
            end else begin
                curve[k] = longint'(((e << FRAC_BITS) + denom / 2) / denom);
            end
        end
    endfunction

    function automatic longint clamp_q(longint v, inout bit hit);
        if (v > DATA_HI) begin
            hit = 1'b1;
            return DATA_HI;
        end
        if (v < DATA_LO) begin
            hit = 1'b1;
            return DATA_LO;
        end
        return v;
    endfunction

    function automatic longint squash(longint net);
        longint lim;
        longint pos;
        longint seg;
        longint frac;
        longint lo_pt;
        longint hi_pt;
        lim = longint'(8) << FRAC_BITS;
        if (net > lim) net = lim;
        if (net < -lim) net = -lim;
        pos  = (net + lim) * (SIG_POINTS - 1);
        seg  = pos >>> (FRAC_BITS + 4);
        frac = pos & ((longint'(1) << (FRAC_BITS + 4)) - 1);
        if (seg >= SIG_POINTS - 1) return curve[SIG_POINTS - 1];
        lo_pt = curve[seg];
        hi_pt = curve[seg + 1];
        return lo_pt + (((hi_pt - lo_pt) * frac + (longint'(1) << (FRAC_BITS + 3)))
                        >>> (FRAC_BITS + 4));
    endfunction

    function automatic bit neuron_step(func_t fn, longint val, longint wgt, bit lst,
                                       output neuron_result_t res);
        longint prod;
        longint slope;
        longint step;
        longint r;
        bit     hit;
        hit   = 1'b0;
        res   = '0;
        slope = (out_q * (ONE_Q - out_q)) >>> FRAC_BITS;
        case (fn)
            FN_FORWARD, FN_HID_GRAD: begin
                prod = val * wgt;
                if (prod > 0 && acc_sum > ACC_HI - prod) begin
                    acc_sum = ACC_HI;
                    acc_ovf = 1'b1;
                end else if (prod < 0 && acc_sum < ACC_LO - prod) begin
                    acc_sum = ACC_LO;
                    acc_ovf = 1'b1;
                end else begin
                    acc_sum = acc_sum + prod;
                end
                if (!lst) return 1'b0;
                hit = acc_ovf;
                if (fn == FN_FORWARD) begin
                    r     = clamp_q(squash(acc_sum >>> FRAC_BITS), hit);
                    out_q = r;
                end else begin
                    r      = clamp_q((slope * (acc_sum >>> FRAC_BITS)) >>> FRAC_BITS, hit);
                    grad_q = r;
                end
                acc_sum = 0;
                acc_ovf = 1'b0;
            end
            FN_OUT_GRAD: begin
                r      = clamp_q(((val - out_q) * slope) >>> FRAC_BITS, hit);
                grad_q = r;
            end
            default: begin
                step = clamp_q((rate * grad_q) >>> RATE_FRAC, hit);
                r    = clamp_q(wgt + ((step * val) >>> FRAC_BITS), hit);
            end
        endcase
        res.value = r[DATA_WIDTH-1:0];
        res.kind  = fn;
        res.sat   = hit;
        return 1'b1;
    endfunction

    initial begin
        fill_curve();
        miss_n = 0;
        seen_n = 0;
        sat_n  = 0;
    end

    always @(posedge aclk) begin
        neuron_result_t got;
        neuron_result_t want;
        neuron_result_t made;
        if (!aresetn) begin
            acc_sum = 0;
            out_q   = 0;
            grad_q  = 0;
            acc_ovf = 1'b0;
            rate    = RATE_RESET;
            due_results.delete();
        end else begin
            if (cfg_we) rate = longint'(cfg_wdata);
            if (m_tvalid && m_tready) begin
                got    = {m_tdata, m_tuser[1:0], m_tuser[2]};
                seen_n = seen_n + 1;
                if (got.sat) sat_n = sat_n + 1;
                if (due_results.size() == 0) begin
                    $display("%0t: result with none due: value %h kind %0d sat %0b",
                             $time, got.value, got.kind, got.sat);
                    miss_n = miss_n + 1;
                end else begin
                    want = due_results.pop_front();
                    if (got.value !== want.value) begin
                        $display("%0t: value mismatch: expected %h, actual %h",
                                 $time, want.value, got.value);
                        miss_n = miss_n + 1;
                    end
                    if (got.kind !== want.kind) begin
                        $display("%0t: kind mismatch: expected %0d, actual %0d",
                                 $time, want.kind, got.kind);
                        miss_n = miss_n + 1;
                    end
                    if (got.sat !== want.sat) begin
                        $display("%0t: saturated mismatch: expected %0b, actual %0b",
                                 $time, want.sat, got.sat);
                        miss_n = miss_n + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (neuron_step(func_t'(s_tuser),
                                longint'($signed(s_tdata[DATA_WIDTH-1:0])),
                                longint'($signed(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH])),
                                s_tlast, made)) begin
                    due_results = {due_results, made};
                end
            end
        end
        outstanding <= due_results.size();
        mismatches  <= miss_n;
        delivered   <= seen_n;
        clamped     <= sat_n;
    end

endmodule

[tb/sv/tb.sv]
module tb;
    import snbu_pkg::*;

    localparam int LIMIT  = 600000;
    localparam int SETTLE = 16;
    localparam int FLOOD  = 520;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // value[15:0], weight[31:16]
    logic                   s_tlast;
    logic [IN_TUSER_W-1:0]  s_tuser;   // func[1:0]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [DATA_WIDTH-1:0]  m_tdata;   // result_value[15:0]
    logic [OUT_TUSER_W-1:0] m_tuser;   // result_kind[1:0], saturated[2]
    logic                   cfg_we;
    logic [RATE_WIDTH-1:0]  cfg_wdata;

    int fails;
    int due;
    int results;
    int clamps;
    int sent;
    int gap_pct;
    int stall_pct;
    bit calm;
    logic [RATE_WIDTH-1:0] mid_rate;

    sigmoid_neuron_backprop_unit_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    neuron_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (fails),
        .outstanding (due),
        .delivered   (results),
        .clamped     (clamps)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        repeat (LIMIT) @(posedge aclk);
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        int hold;
        hold     = 0;
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (hold == 0 && !calm && $urandom_range(99) < stall_pct)
                hold = $urandom_range(12, 1);
            if (calm) hold = 0;
            m_tready = (hold == 0);
            if (hold > 0) hold = hold - 1;
        end
    end

    function automatic logic [DATA_WIDTH-1:0] pick_q();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55) return DATA_WIDTH'($urandom_range(16384) - 8192);
        if (sel < 85) return DATA_WIDTH'($urandom);
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'h1000;
            default: return 16'hf000;
        endcase
    endfunction

    task automatic send(func_t fn, logic [DATA_WIDTH-1:0] val, logic [DATA_WIDTH-1:0] wgt,
                        logic lst);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < gap_pct) gap = $urandom_range(12, 1);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tdata  = {wgt, val};
        s_tuser  = fn;
        s_tlast  = lst;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent = sent + 1;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (due != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_rate(logic [RATE_WIDTH-1:0] r);
        @(negedge aclk);
        cfg_wdata = r;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // hold a full-scale product until the accumulator pins at its bound
    task automatic flood_accumulator(func_t fn, logic [DATA_WIDTH-1:0] val,
                                     logic [DATA_WIDTH-1:0] wgt);
        for (int i = 1; i <= FLOOD; i++) send(fn, val, wgt, i == FLOOD);
    endtask

    task automatic random_traffic(int quota);
        int stop;
        int n;
        int kind;
        stop = sent + quota;
        while (sent < stop) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                n = $urandom_range(8, 1);
                for (int i = 1; i <= n; i++) send(FN_FORWARD, pick_q(), pick_q(), i == n);
                if ($urandom_range(1)) send(FN_OUT_GRAD, pick_q(), pick_q(), 1'($urandom));
            end else if (kind < 55) begin
                n = $urandom_range(6, 1);
                for (int i = 1; i <= n; i++) send(FN_HID_GRAD, pick_q(), pick_q(), i == n);
            end else if (kind < 75) begin
                n = $urandom_range(4, 1);
                for (int i = 1; i <= n; i++)
                    send(FN_UPDATE, pick_q(), pick_q(), 1'($urandom));
            end else if (kind < 85) begin
                send(FN_OUT_GRAD, pick_q(), pick_q(), 1'($urandom));
            end else if (kind < 99) begin
                send(func_t'($urandom_range(3)), DATA_WIDTH'($urandom),
                     DATA_WIDTH'($urandom), 1'($urandom));
            end else begin
                drain();
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        calm      = 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        sent      = 0;
        mid_rate  = RATE_WIDTH'($urandom_range(4095, 2));
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        set_rate(RATE_WIDTH'(RATE_RESET));
        gap_pct   = 25;
        stall_pct = 25;
        send(FN_FORWARD,  16'h7fff, 16'h7fff, 1'b1);
        send(FN_OUT_GRAD, 16'h7fff, 16'h0000, 1'b0);
        send(FN_FORWARD,  16'h8000, 16'h7fff, 1'b1);
        send(FN_OUT_GRAD, 16'h8000, 16'h0000, 1'b1);
        send(FN_FORWARD,  16'h1000, 16'h1000, 1'b0);
        send(FN_FORWARD,  16'h0000, 16'h0000, 1'b1);
        send(FN_FORWARD,  16'h0000, 16'h0000, 1'b1);
        send(FN_OUT_GRAD, 16'h0000, 16'h0000, 1'b0);
        send(FN_HID_GRAD, 16'h7fff, 16'h7fff, 1'b1);
        send(FN_UPDATE,   16'h7fff, 16'h7fff, 1'b1);
        send(FN_UPDATE,   16'h8000, 16'h8000, 1'b0);
        send(FN_HID_GRAD, 16'h7fff, 16'h8000, 1'b1);
        send(FN_UPDATE,   16'h8000, 16'h7fff, 1'b0);
        send(FN_UPDATE,   16'h0000, 16'h0000, 1'b0);
        send(FN_FORWARD,  16'h1000, 16'h0800, 1'b0);
        send(FN_HID_GRAD, 16'h1000, 16'h1000, 1'b1);
        send(FN_UPDATE,   16'h1234, 16'h8000, 1'b1);
        send(FN_FORWARD,  16'hffff, 16'hffff, 1'b0);
        send(FN_HID_GRAD, 16'h0001, 16'hffff, 1'b1);
        drain();

        set_rate(13'd4096);
        gap_pct   = 40;
        stall_pct = 40;
        random_traffic(140);
        flood_accumulator(FN_FORWARD, 16'h8000, 16'h8000);
        send(FN_OUT_GRAD, 16'h0800, 16'h0000, 1'b0);
        random_traffic(40);
        drain();

        set_rate(13'd0);
        gap_pct   = 0;
        stall_pct = 0;
        random_traffic(140);
        drain();

        set_rate(mid_rate);
        gap_pct   = 15;
        stall_pct = 60;
        flood_accumulator(FN_HID_GRAD, 16'h8000, 16'h7fff);
        send(FN_UPDATE, 16'h7fff, 16'h1000, 1'b0);
        random_traffic(140);
        drain();

        set_rate(13'd1);
        gap_pct   = 60;
        stall_pct = 10;
        random_traffic(100);
        drain();

        set_rate(13'd4096);
        calm = 1'b1;
        random_traffic(120);
        drain();

        $display("tb: %0d items sent, %0d results checked, %0d of them saturated",
                 sent, results, clamps);
        $display("tb: learning rates 819, 4096, 0, %0d and 1; both accumulator bounds hit",
                 mid_rate);
        if (fails == 0 && due == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

[sigmoid_neuron_backprop_unit_core.f]
design/snbu_pkg.sv
design/sigmoid_neuron_backprop_unit_core.sv
design/snbu_checker.sv
tb/sv/neuron_checker.sv
tb/sv/tb.sv
